// File: rtl/core/primitive_assembler_macros.svh
// ---------------------------------------------------------------------------
// primitive assembler assertion macros
// Wrappers for the concurrent checks of the assembler. They compile to
// nothing when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLER_MACROS_SVH
`define PRIMITIVE_ASSEMBLER_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition in this cycle implies consequence in this cycle
`define PA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("primitive assembler check failed");
// condition in this cycle implies consequence in the next cycle
`define PA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("primitive assembler check failed");
`else
`define PA_ASSERT_NOW(lbl, ante, cons)
`define PA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/primasm_pkg.sv
// ---------------------------------------------------------------------------
// primasm_pkg
// Shared types and codes of the primitive assembler: request and result
// layouts, command modes, primitive types, result kinds and the
// controller to datapath handshake.
// ---------------------------------------------------------------------------
`default_nettype none

package primasm_pkg;

  // default configuration
  localparam int MAX_VERTS_DEF = 64;
  localparam int ID_BITS_DEF   = 16;
  localparam int ID_W          = 16;

  // command modes
  localparam logic [1:0] MODE_BEGIN  = 2'd0;
  localparam logic [1:0] MODE_VERTEX = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  // primitive types
  localparam logic [3:0] PRIM_POINTS      = 4'd0;
  localparam logic [3:0] PRIM_LINES       = 4'd1;
  localparam logic [3:0] PRIM_LINE_STRIP  = 4'd2;
  localparam logic [3:0] PRIM_LINE_LOOP   = 4'd3;
  localparam logic [3:0] PRIM_TRIANGLES   = 4'd4;
  localparam logic [3:0] PRIM_TRI_STRIP   = 4'd5;
  localparam logic [3:0] PRIM_TRI_FAN     = 4'd6;
  localparam logic [3:0] PRIM_QUADS       = 4'd7;
  localparam logic [3:0] PRIM_QUAD_STRIP  = 4'd8;
  localparam logic [3:0] PRIM_POLYGON     = 4'd9;

  // result kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_TRI   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // one request
  typedef struct packed {
    logic [1:0]      mode;
    logic [3:0]      prim_type;
    logic [ID_W-1:0] vertex_id;
    logic            vtx_flag;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] vert_a;
    logic [ID_W-1:0] vert_b;
    logic [ID_W-1:0] vert_c;
    logic            flag_a;
    logic            flag_b;
    logic            flag_c;
    logic            last;
  } out_item_t;

  // controller commands to the datapath
  typedef struct packed {
    logic accept;   // take the request on the input ports
    logic second;   // emit the held second triangle
    logic walk;     // emit one polygon fan triangle
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic two;        // request yields two triangles
    logic walk;       // request starts a polygon fan walk
    logic walk_last;  // current fan triangle is the final one
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/primasm_ctrl.sv
// ---------------------------------------------------------------------------
// primasm_ctrl
// Sequencer of the primitive assembler: takes requests, holds the block
// busy while a second quad triangle or a polygon fan is being emitted.
// ---------------------------------------------------------------------------
`default_nettype none

module primasm_ctrl import primasm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_status_t status,
  output logic            busy,
  output dp_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SECOND,
    ST_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  // request handshake
  assign accept = start & ~busy_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && status.two) begin
          state_nxt = ST_SECOND;
        end else if (accept && status.walk) begin
          state_nxt = ST_WALK;
        end
      end
      ST_SECOND: begin
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        if (status.walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  // state and busy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // commands
  assign cmd.accept = accept;
  assign cmd.second = (state_r == ST_SECOND);
  assign cmd.walk   = (state_r == ST_WALK);
  assign busy       = busy_r;

endmodule

`default_nettype wire

// File: rtl/core/primasm_dp.sv
// ---------------------------------------------------------------------------
// primasm_dp
// Datapath of the primitive assembler: primitive state, the four working
// vertex slots, the polygon vertex memory and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module primasm_dp import primasm_pkg::*; #(
  parameter int MAX_VERTS = MAX_VERTS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire dp_cmd_t  cmd,
  output dp_status_t    status,
  output logic          out_valid,
  output out_item_t     out_res
);

  localparam int SW    = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int AW    = $clog2(MAX_VERTS);

  // flag in the top bit, id below
  typedef logic [SW:0] slot_t;

  function automatic logic [ID_W-1:0] id_of(slot_t s);
    logic [ID_W-1:0] x;
    x         = '0;
    x[SW-1:0] = s[SW-1:0];
    return x;
  endfunction

  function automatic out_item_t mk_res(logic [1:0] kind, slot_t a, slot_t b, slot_t c,
                                       logic fa, logic fb, logic fc);
    out_item_t r;
    r.kind   = kind;
    r.vert_a = id_of(a);
    r.vert_b = id_of(b);
    r.vert_c = id_of(c);
    r.flag_a = fa;
    r.flag_b = fb;
    r.flag_c = fc;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic out_item_t mk_tri(slot_t a, slot_t b, slot_t c);
    return mk_res(KIND_TRI, a, b, c, a[SW], b[SW], c[SW]);
  endfunction

  // primitive state
  logic             active_r, active_nxt;
  logic [3:0]       cur_type_r, cur_type_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      total_r, total_nxt;
  logic             ovf_r, ovf_nxt;
  slot_t            s_r [4];
  slot_t            s_nxt [4];
  slot_t            last_r, last_nxt;

  // polygon memory and fan walk
  slot_t            mem [MAX_VERTS];
  slot_t            rd_r;
  slot_t            hi_r;
  logic [AW-1:0]    k_r;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  // results
  logic             out_valid_r;
  out_item_t        out_res_r;
  out_item_t        second_r;
  out_item_t        res1, res2, walk_res;
  logic             has1, has2, walk_go;

  // helpers
  slot_t            v;
  slot_t            sv [4];
  logic [CNT_W-1:0] n1;
  logic [CNT_W-1:0] cnt_m2;
  logic [31:0]      tot_inc;

  assign v       = {in_item.vtx_flag, in_item.vertex_id[SW-1:0]};
  assign n1      = count_r + CNT_W'(1);
  assign cnt_m2  = count_r - CNT_W'(2);
  assign tot_inc = total_r + 32'd1;

  // slots as seen after storing the incoming vertex
  always_comb begin
    sv = s_r;
    if (count_r < CNT_W'(4)) begin
      sv[count_r[1:0]] = v;
    end
  end

  // request decode and next primitive state
  always_comb begin
    active_nxt   = active_r;
    cur_type_nxt = cur_type_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;
    s_nxt        = s_r;
    last_nxt     = last_r;
    res1         = '0;
    res2         = '0;
    has1         = 1'b0;
    has2         = 1'b0;
    walk_go      = 1'b0;
    mem_we       = 1'b0;
    case (in_item.mode)
      MODE_BEGIN: begin
        if (active_r || (in_item.prim_type > PRIM_POLYGON)) begin
          res1 = mk_res(KIND_ERR, '0, '0, '0, 1'b0, 1'b0, 1'b0);
          has1 = 1'b1;
        end else begin
          active_nxt   = 1'b1;
          cur_type_nxt = in_item.prim_type;
          count_nxt    = '0;
          total_nxt    = '0;
          ovf_nxt      = 1'b0;
        end
      end
      MODE_VERTEX: begin
        if (!active_r) begin
          res1 = mk_res(KIND_ERR, '0, '0, '0, 1'b0, 1'b0, 1'b0);
          has1 = 1'b1;
        end else if (count_r >= CNT_W'(MAX_VERTS)) begin
          // full polygon: vertex dropped
          total_nxt = tot_inc;
          ovf_nxt   = 1'b1;
        end else begin
          total_nxt = tot_inc;
          s_nxt     = sv;
          count_nxt = n1;
          case (cur_type_r)
            PRIM_POINTS: begin
              res1      = mk_res(KIND_POINT, sv[0], '0, '0, sv[0][SW], 1'b0, 1'b0);
              has1      = 1'b1;
              count_nxt = '0;
            end
            PRIM_LINES: begin
              if (n1 == CNT_W'(2)) begin
                res1      = mk_res(KIND_LINE, sv[0], sv[1], '0, sv[0][SW], sv[1][SW], 1'b0);
                has1      = 1'b1;
                count_nxt = '0;
              end
            end
            PRIM_LINE_STRIP, PRIM_LINE_LOOP: begin
              if (n1 == CNT_W'(1)) begin
                // keep the first vertex for closing a loop
                s_nxt[2] = sv[0];
              end else if (n1 == CNT_W'(2)) begin
                res1      = mk_res(KIND_LINE, sv[0], sv[1], '0, sv[0][SW], sv[1][SW], 1'b0);
                has1      = 1'b1;
                s_nxt[0]  = sv[1];
                count_nxt = CNT_W'(1);
              end
            end
            PRIM_TRIANGLES: begin
              if (n1 == CNT_W'(3)) begin
                res1      = mk_tri(sv[0], sv[1], sv[2]);
                has1      = 1'b1;
                count_nxt = '0;
              end
            end
            PRIM_TRI_STRIP: begin
              if (n1 == CNT_W'(3)) begin
                count_nxt = '0;
              end
              if (tot_inc >= 32'd3) begin
                has1 = 1'b1;
                if (!tot_inc[0]) begin
                  res1 = mk_tri(sv[2], sv[1], sv[0]);
                end else begin
                  res1 = mk_tri(sv[0], sv[1], sv[2]);
                end
              end
            end
            PRIM_TRI_FAN: begin
              if (n1 == CNT_W'(3)) begin
                res1      = mk_tri(sv[0], sv[1], sv[2]);
                has1      = 1'b1;
                s_nxt[1]  = sv[2];
                count_nxt = CNT_W'(2);
              end
            end
            PRIM_QUADS: begin
              if (n1 == CNT_W'(4)) begin
                // inner diagonal edges are hidden
                res1 = mk_res(KIND_TRI, sv[0], sv[1], sv[2], sv[0][SW], sv[1][SW], 1'b0);
                res2 = mk_res(KIND_TRI, sv[0], sv[2], sv[3], 1'b0, 1'b1, sv[3][SW]);
                has1 = 1'b1;
                has2 = 1'b1;
                s_nxt[0][SW] = 1'b0;
                s_nxt[2][SW] = 1'b1;
                count_nxt    = '0;
              end
            end
            PRIM_QUAD_STRIP: begin
              if (n1 == CNT_W'(4)) begin
                res1      = mk_tri(sv[0], sv[1], sv[2]);
                res2      = mk_tri(sv[1], sv[3], sv[2]);
                has1      = 1'b1;
                has2      = 1'b1;
                s_nxt[0]  = sv[2];
                s_nxt[1]  = sv[3];
                count_nxt = CNT_W'(2);
              end
            end
            default: begin
              // polygon: store every vertex for the fan at end
              mem_we   = 1'b1;
              last_nxt = v;
            end
          endcase
        end
      end
      MODE_END: begin
        if (!active_r) begin
          res1 = mk_res(KIND_ERR, '0, '0, '0, 1'b0, 1'b0, 1'b0);
          has1 = 1'b1;
        end else begin
          active_nxt = 1'b0;
          if (cur_type_r == PRIM_LINE_LOOP) begin
            if (total_r >= 32'd3) begin
              res1 = mk_res(KIND_LINE, s_r[0], s_r[2], '0, s_r[0][SW], s_r[2][SW], 1'b0);
              has1 = 1'b1;
            end
          end else if (cur_type_r == PRIM_POLYGON) begin
            if (ovf_r) begin
              res1 = mk_res(KIND_ERR, '0, '0, '0, 1'b0, 1'b0, 1'b0);
              has1 = 1'b1;
            end else if (count_r >= CNT_W'(3)) begin
              walk_go = 1'b1;
            end
          end
        end
      end
      default: begin
        res1 = mk_res(KIND_ERR, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        has1 = 1'b1;
      end
    endcase
    // the held second triangle always ends its request
    res1.last = ~has2;
    res2.last = 1'b1;
  end

  // fan triangle from the walk registers
  always_comb begin
    walk_res      = mk_tri(hi_r, s_r[0], rd_r);
    walk_res.last = (k_r == AW'(1));
  end

  // memory read address: next lower slot of the fan
  assign rd_addr = cmd.walk ? (k_r - AW'(1)) : cnt_m2[AW-1:0];

  // polygon vertex memory
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) begin
      mem[count_r[AW-1:0]] <= v;
    end
    rd_r <= mem[rd_addr];
  end

  // primitive state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      cur_type_r <= PRIM_POINTS;
      count_r    <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.accept) begin
      active_r   <= active_nxt;
      cur_type_r <= cur_type_nxt;
      count_r    <= count_nxt;
      total_r    <= total_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // slot registers and fan walk
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r      <= s_nxt;
      last_r   <= last_nxt;
      second_r <= res2;
      if (walk_go) begin
        hi_r <= last_r;
        k_r  <= cnt_m2[AW-1:0];
      end
    end else if (cmd.walk) begin
      hi_r <= rd_r;
      k_r  <= k_r - AW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.accept & has1) | cmd.second | cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      out_res_r <= walk_res;
    end else if (cmd.second) begin
      out_res_r <= second_r;
    end else if (cmd.accept) begin
      out_res_r <= res1;
    end
  end

  assign status.two       = has2;
  assign status.walk      = walk_go;
  assign status.walk_last = (k_r == AW'(1));
  assign out_valid        = out_valid_r;
  assign out_res          = out_res_r;

endmodule

`default_nettype wire

// File: rtl/core/primitive_assembler.sv
// ---------------------------------------------------------------------------
// primitive_assembler
// Turns begin/vertex/end requests into points, lines and triangles with
// vertex ids and edge flags; misplaced requests give an error result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "primitive_assembler_macros.svh"

// A request is taken on a rising edge with start high and busy low. Each
// result is shown on out_res for exactly one cycle with out_valid high, in
// the cycle after its request or after the previous result, save the first
// fan triangle of a polygon end; the receiver cannot hold results off, and
// last marks the final result of a request. A quad or quad strip vertex that
// closes a quad gives two triangles and holds busy while the second is
// emitted. A polygon end with N stored vertices gives N-2 fan triangles, one
// per cycle out of the single read port of the vertex memory, and holds busy
// while the walk runs. Other requests leave busy low, so requests may follow
// every cycle. The vertex memory needs no clearing after reset.
module primitive_assembler import primasm_pkg::*; #(
  parameter int MAX_VERTS = MAX_VERTS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire in_item_t in_item,
  output logic          busy,
  output logic          out_valid,
  output out_item_t     out_res
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  primasm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // datapath
  primasm_dp #(
    .MAX_VERTS (MAX_VERTS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // every busy cycle produces a result
  `PA_ASSERT_NEXT(a_busy_emits, busy, out_valid)
  // a non-final result keeps new requests out
  `PA_ASSERT_NOW(a_more_holds_busy, out_valid && !out_res.last, busy)
  // an error is always the only result of its request
  `PA_ASSERT_NOW(a_err_is_last, out_valid && (out_res.kind == KIND_ERR), out_res.last)

endmodule

`default_nettype wire

// File: tb/primitive_assembler_tb.sv
// ---------------------------------------------------------------------------
// primitive_assembler_tb
// Drives begin/vertex/end requests into the primitive assembler and checks
// every point, line, triangle and error result against a behavioral
// predictor of the assembler, field by field and in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module primitive_assembler_tb import primasm_pkg::*; ();

  localparam int         SLOTS            = MAX_VERTS_DEF;
  localparam logic [1:0] MODE_UNUSED      = 2'd3;
  localparam logic [3:0] PRIM_INVALID_MAX = 4'hF;
  localparam int         TOTAL_ITEMS      = 150;
  localparam int         QUIET_TAIL       = 30;

  // predicts the primitives of each request and checks them in order
  class prim_scoreboard;
    bit          open_prim;
    logic [3:0]  prim;
    int          nslots;
    logic [31:0] nverts;
    bit          overflowed;
    logic [15:0] slot_id [SLOTS];
    logic        slot_flag [SLOTS];
    out_item_t   pending_prims [$];
    int          bad_prims;

    function void add_prim(logic [1:0] k, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                           logic fa, logic fb, logic fc);
      out_item_t p;
      p = '0;
      p.kind   = k;
      p.vert_a = a;
      p.vert_b = b;
      p.vert_c = c;
      p.flag_a = fa;
      p.flag_b = fb;
      p.flag_c = fc;
      pending_prims.push_back(p);
    endfunction

    function void add_error();
      add_prim(KIND_ERR, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    endfunction

    function void add_line(int i, int j);
      add_prim(KIND_LINE, slot_id[i], slot_id[j], '0, slot_flag[i], slot_flag[j], 1'b0);
    endfunction

    function void add_tri(int i, int j, int k);
      add_prim(KIND_TRI, slot_id[i], slot_id[j], slot_id[k],
               slot_flag[i], slot_flag[j], slot_flag[k]);
    endfunction

    function void copy_slot(int dst, int src);
      slot_id[dst]   = slot_id[src];
      slot_flag[dst] = slot_flag[src];
    endfunction

    // one vertex of the open primitive
    function void add_vertex(logic [15:0] id, logic flag);
      int n;
      n = nslots;
      nverts = nverts + 1;
      if (n >= SLOTS) begin
        overflowed = 1'b1;
        return;
      end
      slot_id[n]   = id;
      slot_flag[n] = flag;
      n++;
      case (prim)
        PRIM_POINTS: begin
          add_prim(KIND_POINT, slot_id[0], '0, '0, slot_flag[0], 1'b0, 1'b0);
          n = 0;
        end
        PRIM_LINES: begin
          if (n == 2) begin
            add_line(0, 1);
            n = 0;
          end
        end
        PRIM_LINE_STRIP, PRIM_LINE_LOOP: begin
          // slot 2 keeps the first vertex for closing a loop
          if (n == 1) begin
            copy_slot(2, 0);
          end else if (n == 2) begin
            add_line(0, 1);
            copy_slot(0, 1);
            n = 1;
          end
        end
        PRIM_TRIANGLES: begin
          if (n == 3) begin
            add_tri(0, 1, 2);
            n = 0;
          end
        end
        PRIM_TRI_STRIP: begin
          // winding flips with the running vertex count
          if (n == 3) n = 0;
          if (nverts >= 3) begin
            if (nverts[0] == 1'b0) add_tri(2, 1, 0);
            else add_tri(0, 1, 2);
          end
        end
        PRIM_TRI_FAN: begin
          if (n == 3) begin
            add_tri(0, 1, 2);
            copy_slot(1, 2);
            n = 2;
          end
        end
        PRIM_QUADS: begin
          // inner diagonal edge flags are forced
          if (n == 4) begin
            add_prim(KIND_TRI, slot_id[0], slot_id[1], slot_id[2],
                     slot_flag[0], slot_flag[1], 1'b0);
            add_prim(KIND_TRI, slot_id[0], slot_id[2], slot_id[3],
                     1'b0, 1'b1, slot_flag[3]);
            slot_flag[0] = 1'b0;
            slot_flag[2] = 1'b1;
            n = 0;
          end
        end
        PRIM_QUAD_STRIP: begin
          if (n == 4) begin
            add_tri(0, 1, 2);
            add_tri(1, 3, 2);
            copy_slot(0, 2);
            copy_slot(1, 3);
            n = 2;
          end
        end
        default: ;
      endcase
      nslots = n;
    endfunction

    // end of the open primitive
    function void close_prim();
      int i;
      if (prim == PRIM_LINE_LOOP) begin
        if (nverts >= 3) add_line(0, 2);
      end else if (prim == PRIM_POLYGON) begin
        if (overflowed) begin
          add_error();
        end else begin
          i = nslots;
          while (i >= 3) begin
            i--;
            add_tri(i, 0, i - 1);
          end
        end
      end
      open_prim = 1'b0;
    endfunction

    // accepted request: queue the primitives it causes
    function void take_request(in_item_t r);
      int n_prior;
      n_prior = pending_prims.size();
      case (r.mode)
        MODE_BEGIN: begin
          if (open_prim || r.prim_type > PRIM_POLYGON) begin
            add_error();
          end else begin
            open_prim  = 1'b1;
            prim       = r.prim_type;
            nslots     = 0;
            nverts     = '0;
            overflowed = 1'b0;
          end
        end
        MODE_VERTEX: begin
          if (!open_prim) add_error();
          else add_vertex(r.vertex_id, r.vtx_flag);
        end
        MODE_END: begin
          if (!open_prim) add_error();
          else close_prim();
        end
        default: add_error();
      endcase
      if (pending_prims.size() > n_prior) pending_prims[pending_prims.size() - 1].last = 1'b1;
    endfunction

    // accepted result: compare with the oldest expected primitive
    function void check_prim(out_item_t got);
      out_item_t want;
      if (pending_prims.size() == 0) begin
        bad_prims++;
        if (bad_prims <= 10)
          $display("unexpected result: kind=%0d a=%h b=%h c=%h flags=%b%b%b last=%b",
                   got.kind, got.vert_a, got.vert_b, got.vert_c,
                   got.flag_a, got.flag_b, got.flag_c, got.last);
        return;
      end
      want = pending_prims.pop_front();
      if (got.kind !== want.kind || got.vert_a !== want.vert_a ||
          got.vert_b !== want.vert_b || got.vert_c !== want.vert_c ||
          got.flag_a !== want.flag_a || got.flag_b !== want.flag_b ||
          got.flag_c !== want.flag_c || got.last !== want.last) begin
        bad_prims++;
        if (bad_prims <= 10) begin
          $display("mismatch: expected kind=%0d a=%h b=%h c=%h flags=%b%b%b last=%b",
                   want.kind, want.vert_a, want.vert_b, want.vert_c,
                   want.flag_a, want.flag_b, want.flag_c, want.last);
          $display("          actual   kind=%0d a=%h b=%h c=%h flags=%b%b%b last=%b",
                   got.kind, got.vert_a, got.vert_b, got.vert_c,
                   got.flag_a, got.flag_b, got.flag_c, got.last);
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_res;

  prim_scoreboard sb = new();
  int  n_sent = 0;
  int  quiet_from = 0;
  bit  bursty = 1'b0;

  primitive_assembler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #5 clk = ~clk;

  // watch both channels at each rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.take_request(in_item);
      if (out_valid) sb.check_prim(out_res);
    end
  end

  function automatic logic [15:0] rand_id();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one request, with an optional idle burst in front of it
  task automatic send_req(input logic [1:0] mode, input logic [3:0] ptype,
                          input logic [15:0] id, input logic flag);
    in_item_t    req;
    logic [31:0] noise;
    int          gap;
    req.mode      = mode;
    req.prim_type = ptype;
    req.vertex_id = id;
    req.vtx_flag  = flag;
    if (bursty && (quiet_from == 0 || n_sent < quiet_from) && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) begin
        noise = $urandom;
        in_item <= noise[$bits(in_item_t)-1:0];
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  // well-formed primitive with random content and rare intrusions
  task automatic run_prim(input logic [3:0] ptype, input int count, input bit intrude);
    int k;
    send_req(MODE_BEGIN, ptype, rand_id(), 1'($urandom));
    for (k = 0; k < count; k++) begin
      if (intrude && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_req(MODE_BEGIN, 4'($urandom), rand_id(), 1'($urandom));
        else
          send_req(MODE_UNUSED, 4'($urandom), rand_id(), 1'($urandom));
      end
      send_req(MODE_VERTEX, 4'($urandom), rand_id(), 1'($urandom));
    end
    send_req(MODE_END, 4'($urandom), rand_id(), 1'($urandom));
  endtask

  // stimulus
  initial begin
    int pick;
    int wait_cnt;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // misplaced requests
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hFFFF, 1'b1);
    send_req(MODE_END, PRIM_POINTS, 16'h0000, 1'b0);
    send_req(MODE_UNUSED, PRIM_INVALID_MAX, 16'hFFFF, 1'b1);
    send_req(MODE_BEGIN, PRIM_POLYGON + 4'd1, 16'h0000, 1'b0);
    // points at the id extremes
    send_req(MODE_BEGIN, PRIM_POINTS, 16'h0000, 1'b0);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hFFFF, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'h0000, 1'b0);
    send_req(MODE_END, PRIM_POINTS, 16'h0000, 1'b0);
    // line loop closing, with a begin inside it
    send_req(MODE_BEGIN, PRIM_LINE_LOOP, 16'h0000, 1'b0);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'h1111, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'h2222, 1'b0);
    send_req(MODE_BEGIN, PRIM_INVALID_MAX, 16'hFFFF, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'h3333, 1'b1);
    send_req(MODE_END, PRIM_POINTS, 16'h0000, 1'b0);
    // strip winding on odd and even counts
    send_req(MODE_BEGIN, PRIM_TRI_STRIP, 16'h0000, 1'b0);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hA001, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hA002, 1'b0);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hA003, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hA004, 1'b1);
    send_req(MODE_END, PRIM_POINTS, 16'h0000, 1'b0);
    // quad edge flag override
    send_req(MODE_BEGIN, PRIM_QUADS, 16'h0000, 1'b0);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hB001, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hB002, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hB003, 1'b1);
    send_req(MODE_VERTEX, PRIM_POINTS, 16'hB004, 1'b0);
    send_req(MODE_END, PRIM_POINTS, 16'h0000, 1'b0);
    // polygon fan at end
    run_prim(PRIM_POLYGON, 5, 1'b0);

    // polygon that overflows the vertex memory
    bursty = 1'b1;
    run_prim(PRIM_POLYGON, SLOTS + $urandom_range(1, 4), 1'b0);

    // random mix of primitives, broken sequences and noise
    quiet_from = TOTAL_ITEMS - QUIET_TAIL;
    while (n_sent < TOTAL_ITEMS) begin
      bursty = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_req(2'($urandom), 4'($urandom), rand_id(), 1'($urandom));
      end else if (pick < 20) begin
        case ($urandom_range(0, 3))
          0: send_req(MODE_VERTEX, 4'($urandom), rand_id(), 1'($urandom));
          1: send_req(MODE_END, 4'($urandom), rand_id(), 1'($urandom));
          2: send_req(MODE_BEGIN, 4'($urandom_range(PRIM_POLYGON + 1, PRIM_INVALID_MAX)),
                      rand_id(), 1'($urandom));
          default: send_req(MODE_UNUSED, 4'($urandom), rand_id(), 1'($urandom));
        endcase
      end else begin
        run_prim(4'($urandom_range(PRIM_POINTS, PRIM_POLYGON)),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 9),
                 1'b1);
      end
    end
    start <= 1'b0;

    // drain
    wait_cnt = 0;
    while (sb.pending_prims.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (16) @(posedge clk);
    if (sb.bad_prims == 0 && sb.pending_prims.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: primitive_assembler.f
+incdir+rtl/core
rtl/core/primasm_pkg.sv
rtl/core/primasm_ctrl.sv
rtl/core/primasm_dp.sv
rtl/core/primitive_assembler.sv
tb/primitive_assembler_tb.sv
